// ----- design/lphi_pkg.sv -----
// Shared types and constants for the linear probing hash insert block.
`timescale 1ns / 1ps
`default_nettype none
package lphi_pkg;

   localparam int KEY_W      = 31;
   localparam int OUT_SLOT_W = 6;
   localparam int SIZE_W     = 7;
   localparam int DIVIDEND_W = 32;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_READ   = 1'b1;

   localparam logic REG_TABLE_SIZE = 1'b0;

   localparam logic [SIZE_W-1:0] TABLE_SIZE_RESET = 7'd64;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HASH,
      ST_PROBE,
      ST_READ,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [SIZE_W-1:0]     divisor;
   } mod_req_type;

   typedef struct packed {
      logic              done;
      logic [SIZE_W-1:0] rem;
   } mod_status_type;

endpackage
`default_nettype wire

// ----- design/linear_probe_hash_insert_top.sv -----
// Top level of the linear probing hash table insert and read block.
//
// Usage: an item beat on req_ carries an opcode in req_tuser (0 insert, 1 read).
// An insert hashes its key to key modulo the table size, then probes forward one
// slot per cycle, wrapping, to the first free slot, stores the key and reports
// the slot. If no slot is free, nothing is written and table_full is set.
// A read reports the key and occupancy of the named slot.
// Exactly one rsp_ beat follows each req_ beat, in order.
// Throughput: one item at a time, req_tready is high only when idle.
// Insert path: the remainder unit (4 bits per cycle) finds the home slot, then the
// one-slot-per-cycle probe walk runs; a full table costs table_size probes plus
// one key read. A read takes its result from the registered key RAM read.
// table_size is written over the csr_ port; 0 acts as 1, values above the depth
// act as the depth. Reset clears all occupancy bits and the stored flag at once.
// The result sits in an output register; while the receiver stalls it holds and
// a new item may be taken, but its result waits until the register frees.
`timescale 1ns / 1ps
`default_nettype none
module linear_probe_hash_insert_top #(
   parameter int TABLE_DEPTH = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // key [30:0], slot_index [36:31], zero [39:37]
   input  wire logic [39:0] req_tdata,
   // opcode [0]
   input  wire logic        req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // slot [5:0], key_out [36:6], occupied [37], table_full [38], any_stored [39]
   output logic [39:0]      rsp_tdata,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import lphi_pkg::*;

   localparam int USED_DEPTH = (TABLE_DEPTH < 127) ? TABLE_DEPTH : 127;
   localparam int SLOT_W     = $clog2(USED_DEPTH);
   localparam logic [SIZE_W-1:0] USED_SIZE = SIZE_W'(USED_DEPTH);
   localparam logic [12:0]       DEPTH_LIM = 13'(TABLE_DEPTH);

   state_type              state_ff, state_in;
   logic [SIZE_W-1:0]      tsize_ff;
   logic [USED_DEPTH-1:0]  valid_ff, valid_in;
   logic                   stored_ff, stored_in;
   logic [SLOT_W-1:0]      pos_ff, pos_in;
   logic [SLOT_W-1:0]      home_ff, home_in;
   logic [SIZE_W-1:0]      cnt_ff, cnt_in;
   logic [KEY_W-1:0]       key_ff, key_in;
   logic                   op_ff, op_in;
   logic [OUT_SLOT_W-1:0]  idx_ff, idx_in;
   logic                   range_ff, range_in;
   logic [OUT_SLOT_W-1:0]  res_slot_ff, res_slot_in;
   logic [KEY_W-1:0]       res_key_ff, res_key_in;
   logic                   res_occ_ff, res_occ_in;
   logic                   res_full_ff, res_full_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic [SIZE_W-1:0]      eff_size;
   logic [SLOT_W-1:0]      pos_next;
   logic                   req_accept;
   logic                   csr_write;
   logic                   hit;
   logic                   ram_we;
   logic [SLOT_W-1:0]      ram_raddr;
   logic [KEY_W-1:0]       ram_rdata;
   mod_req_type            mod_req;
   mod_status_type         mod_st;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_TABLE_SIZE) ? {25'd0, tsize_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         tsize_ff <= TABLE_SIZE_RESET;
      end else if (csr_write && csr_paddr[2] == REG_TABLE_SIZE) begin
         tsize_ff <= csr_pwdata[SIZE_W-1:0];
      end
   end

   always_comb begin
      if (tsize_ff == '0) begin
         eff_size = 7'd1;
      end else if (tsize_ff > USED_SIZE) begin
         eff_size = USED_SIZE;
      end else begin
         eff_size = tsize_ff;
      end
   end

   assign pos_next   = ((SIZE_W'(pos_ff) + 7'd1) == eff_size) ? '0 : pos_ff + 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;

   assign mod_req.start    = req_accept && (req_tuser == OP_INSERT);
   assign mod_req.dividend = {1'b0, req_tdata[KEY_W-1:0]};
   assign mod_req.divisor  = eff_size;

   lphi_mod_unit u_mod (
      .clock  (clock),
      .reset  (reset),
      .req    (mod_req),
      .status (mod_st)
   );

   lphi_ram #(
      .WIDTH (KEY_W),
      .DEPTH (USED_DEPTH)
   ) u_keys (
      .clock (clock),
      .we    (ram_we),
      .waddr (pos_ff),
      .wdata (key_ff),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      stored_in    = stored_ff;
      pos_in       = pos_ff;
      home_in      = home_ff;
      cnt_in       = cnt_ff;
      key_in       = key_ff;
      op_in        = op_ff;
      idx_in       = idx_ff;
      range_in     = range_ff;
      res_slot_in  = res_slot_ff;
      res_key_in   = res_key_ff;
      res_occ_in   = res_occ_ff;
      res_full_in  = res_full_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      ram_we       = 1'b0;
      ram_raddr    = pos_ff;
      hit          = 1'b0;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               key_in   = req_tdata[KEY_W-1:0];
               idx_in   = req_tdata[KEY_W+OUT_SLOT_W-1:KEY_W];
               op_in    = req_tuser;
               if (req_tuser == OP_INSERT) begin
                  state_in = ST_HASH;
               end else begin
                  pos_in    = SLOT_W'(req_tdata[KEY_W+OUT_SLOT_W-1:KEY_W]);
                  ram_raddr = SLOT_W'(req_tdata[KEY_W+OUT_SLOT_W-1:KEY_W]);
                  range_in  = 13'(req_tdata[KEY_W+OUT_SLOT_W-1:KEY_W]) < DEPTH_LIM;
                  state_in  = ST_READ;
               end
            end
         end
         ST_HASH: begin
            if (mod_st.done) begin
               home_in  = SLOT_W'(mod_st.rem);
               pos_in   = SLOT_W'(mod_st.rem);
               cnt_in   = '0;
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            priority if (!valid_ff[pos_ff]) begin
               ram_we           = 1'b1;
               valid_in[pos_ff] = 1'b1;
               stored_in        = 1'b1;
               res_slot_in      = OUT_SLOT_W'(pos_ff);
               res_key_in       = key_ff;
               res_occ_in       = 1'b1;
               res_full_in      = 1'b0;
               state_in         = ST_RESP;
            end else if (cnt_ff == eff_size - 7'd1) begin
               ram_raddr = home_ff;
               state_in  = ST_READ;
            end else begin
               pos_in = pos_next;
               cnt_in = cnt_ff + 7'd1;
            end
         end
         ST_READ: begin
            if (op_ff == OP_INSERT) begin
               res_slot_in = OUT_SLOT_W'(home_ff);
               res_key_in  = ram_rdata;
               res_occ_in  = 1'b1;
               res_full_in = 1'b1;
            end else begin
               hit         = range_ff ? valid_ff[pos_ff] : 1'b0;
               res_slot_in = idx_ff;
               res_key_in  = hit ? ram_rdata : '0;
               res_occ_in  = hit;
               res_full_in = 1'b0;
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = {stored_ff, res_full_ff, res_occ_ff, res_key_ff, res_slot_ff};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         stored_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         stored_ff    <= stored_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
      pos_ff      <= pos_in;
      home_ff     <= home_in;
      key_ff      <= key_in;
      op_ff       <= op_in;
      idx_ff      <= idx_in;
      range_ff    <= range_in;
      res_slot_ff <= res_slot_in;
      res_key_ff  <= res_key_in;
      res_occ_ff  <= res_occ_in;
      res_full_ff <= res_full_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_probe_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE) |-> (SIZE_W'(pos_ff) < eff_size))
      else $error("probe position beyond table size");

   a_done_in_hash: assert property (@(posedge clock) disable iff (reset)
      mod_st.done |-> (state_ff == ST_HASH))
      else $error("remainder done outside hash state");

   a_write_sets_valid: assert property (@(posedge clock) disable iff (reset)
      ram_we |=> valid_ff[$past(pos_ff)])
      else $error("key written without occupancy set");

   a_stored_sticky: assert property (@(posedge clock) disable iff (reset)
      !$fell(stored_ff))
      else $error("stored flag cleared");

   a_full_is_occupied: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP && res_full_ff) |-> res_occ_ff)
      else $error("refused insert not marked occupied");

endmodule
`default_nettype wire

// ----- design/lphi_ram.sv -----
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module lphi_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ----- design/lphi_mod_unit.sv -----
// Iterative remainder unit, four restoring steps per cycle over a 32-bit dividend.
`timescale 1ns / 1ps
`default_nettype none
module lphi_mod_unit (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire lphi_pkg::mod_req_type   req,
   output lphi_pkg::mod_status_type     status
);
   import lphi_pkg::*;

   localparam int STEPS = 4;
   localparam int CNT_W = $clog2(DIVIDEND_W / STEPS);
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(DIVIDEND_W / STEPS - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] div_ff, div_in;
   logic [SIZE_W-1:0]     dsr_ff, dsr_in;
   logic [SIZE_W-1:0]     rem_ff, rem_in;

   always_comb begin
      logic [SIZE_W-1:0] r;
      logic [SIZE_W:0]   t;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      div_in  = div_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      r       = rem_ff;
      t       = '0;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         div_in  = req.dividend;
         dsr_in  = req.divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         for (int i = 0; i < STEPS; i++) begin
            t = {r, div_ff[DIVIDEND_W-1-i]};
            if (t >= {1'b0, dsr_ff}) begin
               t = t - {1'b0, dsr_ff};
            end
            r = t[SIZE_W-1:0];
         end
         rem_in = r;
         div_in = div_ff << STEPS;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_CNT) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      div_ff <= div_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign status.done = done_ff;
   assign status.rem  = rem_ff;

endmodule
`default_nettype wire
